// File: rtl/core/wrp_pkg.sv
// Shared constants for the water ripple propagation block.
package wrp_pkg;

	localparam int FRAME_WIDTH_DEF  = 288;
	localparam int FRAME_HEIGHT_DEF = 224;
	localparam int HEIGHT_BITS_DEF  = 16;

	// Position outputs cover frames of up to 1024 by 1024 pixels
	localparam int POS_BITS  = 10;
	localparam int DAMP_BITS = 5;

	localparam logic [DAMP_BITS-1:0] DAMP_RESET = DAMP_BITS'(4);

	// Neighbour sum is divided by four
	localparam int SUM_SHIFT = 2;

endpackage

// File: rtl/core/water_ripple_propagation.sv
// Water ripple stencil: line memories, 3x3 window and damped, saturated height update.
//
//  channel   | handshake                   | word
//  ----------+-----------------------------+----------------------------------------
//  pixel     | pixel_valid / pixel_ready   | cur_height, prev_height, frame_start
//  result    | result_valid / result_ready | new_height, pos_x, pos_y
//  config    | cfg_wr_en (no wait)         | cfg_wr_data -> damping_shift
//
//  One pixel word per clock while pixel_ready is high. After its pixel is taken, a result
//  word passes these steps: the taking edge reads the line and delay memories, then
//  come window load, neighbour sum, subtract, and damp with saturate.
//  arst_n clears the counters, window and stage valids; the memories are not cleared.
//  Each stage moves when the one after it is empty or moving, so pixel_ready drops
//  only when all five stages hold words and the result is not taken.
module water_ripple_propagation #(
	parameter int FRAME_WIDTH  = wrp_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = wrp_pkg::FRAME_HEIGHT_DEF,
	parameter int HEIGHT_BITS  = wrp_pkg::HEIGHT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wrp_pkg::DAMP_BITS-1:0]       cfg_wr_data,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  logic signed [HEIGHT_BITS-1:0]       cur_height,
	input  logic signed [HEIGHT_BITS-1:0]       prev_height,
	input  logic                                frame_start,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [HEIGHT_BITS-1:0]       new_height,
	output logic [wrp_pkg::POS_BITS-1:0]        pos_x,
	output logic [wrp_pkg::POS_BITS-1:0]        pos_y
);
	import wrp_pkg::*;

	localparam int CW = $clog2(FRAME_WIDTH);
	localparam int RW = $clog2(FRAME_HEIGHT);
	localparam int DW = $clog2(FRAME_WIDTH + 1);
	localparam int HB = HEIGHT_BITS;
	localparam int SW = HEIGHT_BITS + 3;
	localparam int HW = HEIGHT_BITS + 2;

	localparam logic [CW-1:0] COL_LAST = CW'(FRAME_WIDTH - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(FRAME_HEIGHT - 1);
	localparam logic [DW-1:0] DLY_LAST = DW'(FRAME_WIDTH);
	localparam logic [CW-1:0] COL_FIRST_INT = CW'(2);
	localparam logic [RW-1:0] ROW_FIRST_INT = RW'(2);

	localparam logic signed [HW-1:0] SAT_HI = HW'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
	localparam logic signed [HW-1:0] SAT_LO = -SAT_HI - HW'(1);

	// Configuration
	logic [DAMP_BITS-1:0] damp_q;

	// Raster position of the next pixel and delay line slot
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [DW-1:0] dptr_q;

	logic [CW-1:0] col_a;
	logic [RW-1:0] row_a;
	logic [DW-1:0] dslot_a;
	logic          col_end, row_end;
	logic          accept;

	// Memories: two rows of heights packed by row parity, previous-frame delay line
	logic [2*HB-1:0]        line_mem [FRAME_WIDTH];
	logic signed [HB-1:0]   dly_mem  [FRAME_WIDTH + 1];

	// Stage 1: memory read data and pixel word
	logic                   v_s1;
	logic [2*HB-1:0]        line_rd_s1;
	logic signed [HB-1:0]   old_rd_s1;
	logic signed [HB-1:0]   cur_s1;
	logic                   par_s1;
	logic                   res_s1;
	logic [POS_BITS-1:0]    posx_s1, posy_s1;

	// Stage 2: window holds this pixel's neighbourhood
	logic signed [HB-1:0]   win_q [9];
	logic                   v_s2;
	logic signed [HB-1:0]   older_s2;
	logic [POS_BITS-1:0]    posx_s2, posy_s2;

	// Stage 3: neighbour sum
	logic                   v_s3;
	logic signed [SW-1:0]   sum_s3;
	logic signed [HB-1:0]   older_s3;
	logic [POS_BITS-1:0]    posx_s3, posy_s3;

	// Stage 4: undamped height
	logic                   v_s4;
	logic signed [HW-1:0]   h_s4;
	logic [POS_BITS-1:0]    posx_s4, posy_s4;

	// Output register
	logic                   result_valid_q;
	logic signed [HB-1:0]   new_height_q;
	logic [POS_BITS-1:0]    pos_x_q, pos_y_q;

	logic free1, free2, free3, free4, out_free;
	logic signed [HW-1:0] damp_h;
	logic signed [HB-1:0] win_top, win_mid;

	// Stage flow
	always_comb begin
		out_free = !result_valid_q || result_ready;
		free4    = !v_s4 || out_free;
		free3    = !v_s3 || free4;
		free2    = !v_s2 || free3;
		free1    = !v_s1 || free2;
	end

	assign pixel_ready = free1;
	assign accept      = pixel_valid && free1;

	// Position of the pixel being taken
	always_comb begin
		col_a   = frame_start ? '0 : col_q;
		row_a   = frame_start ? '0 : row_q;
		dslot_a = frame_start ? '0 : dptr_q;
		col_end = (col_a == COL_LAST);
		row_end = (row_a == ROW_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damp_q <= DAMP_RESET;
		end else if (cfg_wr_en) begin
			damp_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			dptr_q <= '0;
		end else if (accept) begin
			col_q <= col_end ? '0 : col_a + CW'(1);
			if (col_end) begin
				row_q <= row_end ? '0 : row_a + RW'(1);
			end else begin
				row_q <= row_a;
			end
			// restart the delay slot with the raster, otherwise wrap at one row plus one
			if ((col_end && row_end) || dslot_a == DLY_LAST) begin
				dptr_q <= '0;
			end else begin
				dptr_q <= dslot_a + DW'(1);
			end
		end
	end

	// Read old contents and write the new word at the same entry
	always_ff @(posedge clk) begin
		if (accept) begin
			line_rd_s1        <= line_mem[col_a];
			old_rd_s1         <= dly_mem[dslot_a];
			dly_mem[dslot_a]  <= prev_height;
			if (row_a[0]) begin
				line_mem[col_a][2*HB-1:HB] <= cur_height;
			end else begin
				line_mem[col_a][HB-1:0] <= cur_height;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free1) begin
			cur_s1  <= cur_height;
			par_s1  <= row_a[0];
			res_s1  <= (col_a >= COL_FIRST_INT) && (row_a >= ROW_FIRST_INT);
			posx_s1 <= POS_BITS'(col_a) - POS_BITS'(1);
			posy_s1 <= POS_BITS'(row_a) - POS_BITS'(1);
		end
	end

	// Slot of this row's parity holds two rows up, the other slot the row above
	always_comb begin
		win_top = par_s1 ? line_rd_s1[2*HB-1:HB] : line_rd_s1[HB-1:0];
		win_mid = par_s1 ? line_rd_s1[HB-1:0]    : line_rd_s1[2*HB-1:HB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1 && free2) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3 + 1];
				win_q[r*3 + 1] <= win_q[r*3 + 2];
			end
			win_q[2] <= win_top;
			win_q[5] <= win_mid;
			win_q[8] <= cur_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (free2) begin
			older_s2 <= old_rd_s1;
			posx_s2  <= posx_s1;
			posy_s2  <= posy_s1;
		end
		if (free3) begin
			sum_s3 <= SW'(win_q[0]) + SW'(win_q[1]) + SW'(win_q[2]) + SW'(win_q[3])
				+ SW'(win_q[5]) + SW'(win_q[6]) + SW'(win_q[7]) + SW'(win_q[8]);
			older_s3 <= older_s2;
			posx_s3  <= posx_s2;
			posy_s3  <= posy_s2;
		end
		if (free4) begin
			h_s4    <= HW'(sum_s3 >>> SUM_SHIFT) - HW'(older_s3);
			posx_s4 <= posx_s3;
			posy_s4 <= posy_s3;
		end
	end

	// Damping keeps the value between zero and h, so HW bits suffice
	assign damp_h = h_s4 - (h_s4 >>> damp_q);

	always_ff @(posedge clk) begin
		if (out_free && v_s4) begin
			priority if (damp_h > SAT_HI) begin
				new_height_q <= HB'(SAT_HI);
			end else if (damp_h < SAT_LO) begin
				new_height_q <= HB'(SAT_LO);
			end else begin
				new_height_q <= HB'(damp_h);
			end
			pos_x_q <= posx_s4;
			pos_y_q <= posy_s4;
		end
	end

	// Stage valids; border pixels drop out after the window load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (free1) begin
				v_s1 <= accept;
			end
			if (free2) begin
				v_s2 <= v_s1 && res_s1;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
			if (free4) begin
				v_s4 <= v_s3;
			end
			if (out_free) begin
				result_valid_q <= v_s4;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign new_height   = new_height_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;

endmodule

// File: rtl/core/wrp_checker.sv
// Port-level checks for the water ripple block, bound to its top level.
module wrp_checker #(
	parameter int FRAME_WIDTH  = wrp_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = wrp_pkg::FRAME_HEIGHT_DEF,
	parameter int HEIGHT_BITS  = wrp_pkg::HEIGHT_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pixel_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic signed [HEIGHT_BITS-1:0] new_height,
	input logic [wrp_pkg::POS_BITS-1:0]  pos_x,
	input logic [wrp_pkg::POS_BITS-1:0]  pos_y
);
	import wrp_pkg::*;

	// Hold a stalled result word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(new_height) && $stable(pos_x) && $stable(pos_y))
		else $error("result word changed while stalled");

	// Back-pressure at the input only when the output is blocked
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> result_valid && !result_ready)
		else $error("pixel_ready low while the result side is free");

	a_pos_x_interior: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pos_x >= POS_BITS'(1) && pos_x <= POS_BITS'(FRAME_WIDTH - 2))
		else $error("pos_x outside the interior");

	a_pos_y_interior: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pos_y >= POS_BITS'(1) && pos_y <= POS_BITS'(FRAME_HEIGHT - 2))
		else $error("pos_y outside the interior");

endmodule

bind water_ripple_propagation wrp_checker #(
	.FRAME_WIDTH  (FRAME_WIDTH),
	.FRAME_HEIGHT (FRAME_HEIGHT),
	.HEIGHT_BITS  (HEIGHT_BITS)
) u_wrp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_ready  (pixel_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.new_height   (new_height),
	.pos_x        (pos_x),
	.pos_y        (pos_y)
);
